FILE: hdl/wssh_pkg.sv
// Shared types and constants for the WebAssembly section header scanner.
`default_nettype none
package wssh_pkg;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_VERSION,
		PH_TYPE,
		PH_SIZE,
		PH_BODY,
		PH_HALT
	} phase_t;

	typedef enum logic [2:0] {
		FLT_NONE      = 3'd0,
		FLT_MAGIC     = 3'd1,
		FLT_VERSION   = 3'd2,
		FLT_TRUNCATED = 3'd3,
		FLT_ORDER     = 3'd4,
		FLT_UNKNOWN   = 3'd5,
		FLT_OVERRUN   = 3'd6,
		FLT_VARINT    = 3'd7
	} fault_t;

	localparam logic [1:0] REC_SECTION = 2'd0;
	localparam logic [1:0] REC_ACCEPT  = 2'd1;
	localparam logic [1:0] REC_REJECT  = 2'd2;

	localparam logic [2:0] LEB_LAST_STEP = 3'd4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int TDATA_W = 80;

	localparam logic [31:0] MAGIC_RESET   = 32'h6D73_6100;
	localparam logic [31:0] VERSION_RESET = 32'h0000_0001;

	localparam logic [2:0] ADDR_MAGIC   = 3'd0;
	localparam logic [2:0] ADDR_VERSION = 3'd4;

	typedef struct packed {
		logic        sect_valid;
		logic [7:0]  section_kind;
		logic [31:0] section_length;
		logic [31:0] body_position;
		logic        verdict_valid;
		fault_t      fault_code;
	} rec_entry_t;

endpackage
`default_nettype wire

FILE: hdl/wssh_front.sv
// Front end: per-byte header, type, size and body tracking; builds record entries.
`default_nettype none
module wssh_front
	import wssh_pkg::*;
#(
	parameter int MAX_SECTION_KIND = 11
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_module,
	input  wire logic [31:0] expected_magic,
	input  wire logic [31:0] expected_version,
	output logic             push,
	output rec_entry_t       entry
);

	localparam logic [7:0] MAX_KIND = 8'(MAX_SECTION_KIND);

	phase_t      phase_q, phase_n;
	logic [31:0] word_q, word_n, word_acc;
	logic [1:0]  cnt_q, cnt_n;
	logic [31:0] acc_q, acc_n, acc_add;
	logic [2:0]  step_q, step_n;
	logic [5:0]  shamt;
	logic [31:0] rem_q, rem_n;
	logic [7:0]  cur_q, cur_n;
	logic [3:0]  prev_q, prev_n;
	logic [31:0] pos_q, pos_n;
	fault_t      fault_q, fault_n, code;
	logic        sect_v;
	logic [31:0] want;

	always_comb begin
		phase_n  = phase_q;
		word_n   = word_q;
		cnt_n    = cnt_q;
		acc_n    = acc_q;
		step_n   = step_q;
		rem_n    = rem_q;
		cur_n    = cur_q;
		prev_n   = prev_q;
		pos_n    = pos_q + 32'd1;
		fault_n  = fault_q;
		sect_v   = 1'b0;
		code     = FLT_NONE;
		word_acc = word_q | ({24'd0, data_byte} << {cnt_q, 3'b000});
		shamt    = {step_q, 3'b000} - {3'b000, step_q};
		acc_add  = {25'd0, data_byte[6:0]} << shamt;
		want     = (phase_q == PH_MAGIC) ? expected_magic : expected_version;

		case (phase_q)
			PH_MAGIC, PH_VERSION: begin
				cnt_n  = cnt_q + 2'd1;
				word_n = word_acc;
				if (cnt_q == 2'd3) begin
					word_n = '0;
					if (word_acc == want) begin
						phase_n = (phase_q == PH_MAGIC) ? PH_VERSION : PH_TYPE;
					end else begin
						fault_n = (phase_q == PH_MAGIC) ? FLT_MAGIC : FLT_VERSION;
						phase_n = PH_HALT;
					end
				end
			end
			PH_TYPE: begin
				if (data_byte > MAX_KIND) begin
					fault_n = FLT_UNKNOWN;
					phase_n = PH_HALT;
				end else if (data_byte != 8'd0 && data_byte <= {4'd0, prev_q}) begin
					fault_n = FLT_ORDER;
					phase_n = PH_HALT;
				end else begin
					cur_n = data_byte;
					if (data_byte != 8'd0) begin
						prev_n = data_byte[3:0];
					end
					acc_n   = '0;
					step_n  = '0;
					phase_n = PH_SIZE;
				end
			end
			PH_SIZE: begin
				if (step_q == LEB_LAST_STEP && data_byte[7:4] != 4'd0) begin
					fault_n = FLT_VARINT;
					phase_n = PH_HALT;
				end else begin
					acc_n = acc_q | acc_add;
					if (data_byte[7]) begin
						step_n = step_q + 3'd1;
					end else begin
						sect_v  = 1'b1;
						rem_n   = acc_n;
						phase_n = (acc_n != 32'd0) ? PH_BODY : PH_TYPE;
					end
				end
			end
			PH_BODY: begin
				rem_n = rem_q - 32'd1;
				if (rem_n == 32'd0) begin
					phase_n = PH_TYPE;
				end
			end
			default: begin
			end
		endcase

		if (end_of_module) begin
			code = fault_n;
			if (code == FLT_NONE && phase_n != PH_TYPE) begin
				code = (phase_n == PH_BODY) ? FLT_OVERRUN : FLT_TRUNCATED;
			end
		end

		entry.sect_valid     = sect_v;
		entry.section_kind   = cur_q;
		entry.section_length = acc_n;
		entry.body_position  = pos_q + 32'd1;
		entry.verdict_valid  = end_of_module;
		entry.fault_code     = code;
		push = take && (sect_v || end_of_module);

		if (end_of_module) begin
			phase_n = PH_MAGIC;
			word_n  = '0;
			cnt_n   = '0;
			acc_n   = '0;
			step_n  = '0;
			rem_n   = '0;
			cur_n   = '0;
			prev_n  = '0;
			pos_n   = '0;
			fault_n = FLT_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			word_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			step_q  <= '0;
			rem_q   <= '0;
			cur_q   <= '0;
			prev_q  <= '0;
			pos_q   <= '0;
			fault_q <= FLT_NONE;
		end else if (take) begin
			phase_q <= phase_n;
			word_q  <= word_n;
			cnt_q   <= cnt_n;
			acc_q   <= acc_n;
			step_q  <= step_n;
			rem_q   <= rem_n;
			cur_q   <= cur_n;
			prev_q  <= prev_n;
			pos_q   <= pos_n;
			fault_q <= fault_n;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/wssh_queue.sv
// Short record queue between the front end and the output stage.
`default_nettype none
module wssh_queue
	import wssh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire rec_entry_t  push_entry,
	input  wire logic        pop,
	output rec_entry_t       head,
	output logic             not_empty,
	output logic             not_full
);

	rec_entry_t         mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wptr_q, rptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign not_empty = count_q != '0;
	assign not_full  = count_q != QCNT_W'(QDEPTH);
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/wssh_back.sv
// Output stage: expands a queued entry into section and verdict transfers.
`default_nettype none
module wssh_back
	import wssh_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rec_entry_t    head,
	input  wire logic          head_valid,
	output logic               pop,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [TDATA_W-1:0] out_data,
	output logic [1:0]         out_kind,
	output logic               out_last
);

	rec_entry_t entry_q;
	logic       sect_pend_q, verd_pend_q;
	logic       xfer, finishing;
	logic [7:0]  kind;
	logic [31:0] len, bpos;
	fault_t      flt;

	assign out_valid = sect_pend_q | verd_pend_q;
	assign xfer      = out_valid && out_ready;
	assign finishing = xfer && !(sect_pend_q && verd_pend_q);
	assign pop       = head_valid && (!out_valid || finishing);

	always_comb begin
		if (sect_pend_q) begin
			out_kind = REC_SECTION;
			kind     = entry_q.section_kind;
			len      = entry_q.section_length;
			bpos     = entry_q.body_position;
			flt      = FLT_NONE;
		end else begin
			out_kind = (entry_q.fault_code == FLT_NONE) ? REC_ACCEPT : REC_REJECT;
			kind     = '0;
			len      = '0;
			bpos     = '0;
			flt      = entry_q.fault_code;
		end
		out_last = !sect_pend_q;
		out_data = {5'd0, flt, bpos, len, kind};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			entry_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sect_pend_q <= 1'b0;
			verd_pend_q <= 1'b0;
		end else if (pop) begin
			sect_pend_q <= head.sect_valid;
			verd_pend_q <= head.verdict_valid;
		end else if (xfer) begin
			if (sect_pend_q) begin
				sect_pend_q <= 1'b0;
			end else begin
				verd_pend_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/wasm_section_header_scanner_unit.sv
// Top level of the WebAssembly section header scanner.
// Usage:
//   Module image bytes enter on the s_axis stream, one byte per transfer, with
//   tlast on the final byte of each module. The m_axis stream carries records:
//   tuser is the record kind (section found, accepted, rejected), tlast marks
//   the verdict record that closes a module.
//   The APB port holds the expected magic (address 0) and version (address 4);
//   write them only while no module is in progress.
// Timing:
//   One byte is accepted per cycle while the record queue has room. A record
//   passes through the record queue and then the output register before it
//   is presented on m_axis. A byte that yields both a section record and a
//   verdict gives two output transfers from one queue entry.
//   A four-entry record queue sits between the byte parser and the output
//   stage; s_axis_tready drops only when that queue is full, so a stalled
//   receiver first fills the queue and then holds the input.
// Reset:
//   arst_n clears the parser to the magic phase, empties the queue and loads
//   the register reset values.
`default_nettype none
module wasm_section_header_scanner_unit
	import wssh_pkg::*;
#(
	parameter int MAX_SECTION_KIND = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [7:0]         s_axis_tdata,  // data_byte
	input  wire logic               s_axis_tlast,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// section_kind[7:0], section_length[39:8], body_position[71:40], fault_code[74:72]
	output logic [TDATA_W-1:0]      m_axis_tdata,
	output logic [1:0]              m_axis_tuser,  // record_kind
	output logic                    m_axis_tlast,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [31:0] magic_q, version_q;
	logic        take, push, pop, q_not_empty, q_not_full, cfg_wr;
	rec_entry_t  push_entry, head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[2] ? version_q : magic_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= MAGIC_RESET;
			version_q <= VERSION_RESET;
		end else if (cfg_wr) begin
			case (paddr & ADDR_VERSION)
				ADDR_MAGIC:   magic_q   <= pwdata;
				ADDR_VERSION: version_q <= pwdata;
				default:      magic_q   <= magic_q;
			endcase
		end
	end

	assign s_axis_tready = q_not_full;
	assign take          = s_axis_tvalid && s_axis_tready;

	wssh_front #(
		.MAX_SECTION_KIND(MAX_SECTION_KIND)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.data_byte        (s_axis_tdata),
		.end_of_module    (s_axis_tlast),
		.expected_magic   (magic_q),
		.expected_version (version_q),
		.push             (push),
		.entry            (push_entry)
	);

	wssh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.not_empty  (q_not_empty),
		.not_full   (q_not_full)
	);

	wssh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (q_not_empty),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_kind   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

endmodule
`default_nettype wire

FILE: hdl/wssh_checker.sv
// Port-level checks for the scanner top level, with its bind statement.
`default_nettype none
module wssh_checker
	import wssh_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               m_axis_tvalid,
	input wire logic               m_axis_tready,
	input wire logic [TDATA_W-1:0] m_axis_tdata,
	input wire logic [1:0]         m_axis_tuser,
	input wire logic               m_axis_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	a_section_rec: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == REC_SECTION |->
		!m_axis_tlast && m_axis_tdata[74:72] == 3'd0)
		else $error("section record with verdict marks");

	a_accept_rec: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == REC_ACCEPT |->
		m_axis_tlast && m_axis_tdata[74:0] == 75'd0)
		else $error("accept record malformed");

	a_reject_rec: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == REC_REJECT |->
		m_axis_tlast && m_axis_tdata[74:72] != 3'd0 && m_axis_tdata[71:0] == 72'd0)
		else $error("reject record malformed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser == REC_SECTION || m_axis_tuser == REC_ACCEPT
		|| m_axis_tuser == REC_REJECT)
		else $error("illegal record kind");

endmodule

bind wasm_section_header_scanner_unit wssh_checker u_wssh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
